// ===== rtl/core/ebtq_pkg.sv =====
// Shared types and constants for the encoder, button and touch qualifier.
// No dependencies; every other file of the block imports this package.
package ebtq_pkg;

   // Configuration register file geometry
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int TIME_W     = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_LOCKOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOUCH_POLL      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TOUCH_LOCKOUT   = 2'd3;

   // Register reset values in ms
   localparam logic [CSR_DATA_W-1:0] LONG_PRESS_RST      = 16'd600;
   localparam logic [CSR_DATA_W-1:0] RELEASE_LOCKOUT_RST = 16'd180;
   localparam logic [CSR_DATA_W-1:0] TOUCH_POLL_RST      = 16'd15;
   localparam logic [CSR_DATA_W-1:0] TOUCH_LOCKOUT_RST   = 16'd220;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] long_press_ms;
      logic [CSR_DATA_W-1:0] release_lockout_ms;
      logic [CSR_DATA_W-1:0] touch_poll_ms;
      logic [CSR_DATA_W-1:0] touch_lockout_ms;
   } ebtq_cfg_type;

   typedef struct packed {
      logic              encoder_a;
      logic              encoder_b;
      logic              switch_pressed;
      logic              touch_active;
      logic [TIME_W-1:0] now_ms;
   } ebtq_item_type;

   typedef struct packed {
      logic step_clockwise;
      logic step_counter_clockwise;
      logic short_press;
      logic long_press;
      logic touch_press;
   } ebtq_result_type;

endpackage

// ===== rtl/core/ebtq_if.sv =====
// Valid/ready channel interfaces for the qualifier: poll requests, results
// and configuration writes. Depends on ebtq_pkg for widths.
interface ebtq_req_if import ebtq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              encoder_a;
   logic              encoder_b;
   logic              switch_pressed;
   logic              touch_active;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, encoder_a, encoder_b, switch_pressed, touch_active, now_ms,
                   input ready);
   modport sink   (input valid, encoder_a, encoder_b, switch_pressed, touch_active, now_ms,
                   output ready);
endinterface

interface ebtq_rsp_if;
   logic valid;
   logic ready;
   logic step_clockwise;
   logic step_counter_clockwise;
   logic short_press;
   logic long_press;
   logic touch_press;

   modport source (output valid, step_clockwise, step_counter_clockwise, short_press,
                   long_press, touch_press, input ready);
   modport sink   (input valid, step_clockwise, step_counter_clockwise, short_press,
                   long_press, touch_press, output ready);
endinterface

interface ebtq_csr_if import ebtq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ebtq_csr.sv =====
// Configuration register bank: four 16-bit timing registers.
// Depends on ebtq_pkg and the ebtq_csr_if interface.
module ebtq_csr
   import ebtq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   ebtq_csr_if.sink         csr_chan,
   output ebtq_cfg_type     cfg
);

   ebtq_cfg_type cfg_ff;
   ebtq_cfg_type cfg_in;

   // Always ready; a write lands in the addressed register
   assign csr_chan.ready = 1'b1;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_LONG_PRESS:      cfg_in.long_press_ms      = csr_chan.data;
            REG_RELEASE_LOCKOUT: cfg_in.release_lockout_ms = csr_chan.data;
            REG_TOUCH_POLL:      cfg_in.touch_poll_ms      = csr_chan.data;
            REG_TOUCH_LOCKOUT:   cfg_in.touch_lockout_ms   = csr_chan.data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms      <= LONG_PRESS_RST;
         cfg_ff.release_lockout_ms <= RELEASE_LOCKOUT_RST;
         cfg_ff.touch_poll_ms      <= TOUCH_POLL_RST;
         cfg_ff.touch_lockout_ms   <= TOUCH_LOCKOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/ebtq_qual.sv =====
// Event qualification for one poll: encoder direction, press length with
// release lockout, polled touch edge with lockout. Depends on ebtq_pkg.
module ebtq_qual
   import ebtq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ebtq_cfg_type    cfg,
   input  ebtq_item_type   item,
   input  logic            step,
   output ebtq_result_type result
);

   logic              prev_a_ff,        prev_a_in;
   logic              switch_held_ff,   switch_held_in;
   logic [TIME_W-1:0] press_start_ff,   press_start_in;
   logic [TIME_W-1:0] last_release_ff,  last_release_in;
   logic [TIME_W-1:0] last_poll_ff,     last_poll_in;
   logic              prev_touch_ff,    prev_touch_in;
   logic [TIME_W-1:0] last_edge_ff,     last_edge_in;

   logic              rise_a;
   logic              press_start;
   logic              release_seen;
   logic [TIME_W-1:0] held_ms;
   logic              release_ok;
   logic              poll_due;
   logic              touch_ok;
   logic              touch_hit;
   logic              is_long;

   // Elapsed times wrap modulo 2^32
   assign held_ms    = item.now_ms - press_start_ff;
   assign release_ok = (item.now_ms - last_release_ff) >=
                       {{(TIME_W-CSR_DATA_W){1'b0}}, cfg.release_lockout_ms};
   assign poll_due   = (item.now_ms - last_poll_ff) >=
                       {{(TIME_W-CSR_DATA_W){1'b0}}, cfg.touch_poll_ms};
   assign touch_ok   = (item.now_ms - last_edge_ff) >=
                       {{(TIME_W-CSR_DATA_W){1'b0}}, cfg.touch_lockout_ms};
   assign is_long    = held_ms >= {{(TIME_W-CSR_DATA_W){1'b0}}, cfg.long_press_ms};

   // Edge detection
   assign rise_a       = item.encoder_a & ~prev_a_ff;
   assign press_start  = item.switch_pressed & ~switch_held_ff;
   assign release_seen = ~item.switch_pressed & switch_held_ff;
   assign touch_hit    = poll_due & item.touch_active & ~prev_touch_ff & touch_ok;

   // Result bits; A is high on a rise, so B low means clockwise
   always_comb begin
      result.step_clockwise         = rise_a & ~item.encoder_b;
      result.step_counter_clockwise = rise_a & item.encoder_b;
      result.short_press            = release_seen & release_ok & ~is_long;
      result.long_press             = release_seen & release_ok & is_long;
      result.touch_press            = touch_hit;
   end

   // Next state, advanced only when a poll is consumed
   always_comb begin
      prev_a_in       = prev_a_ff;
      switch_held_in  = switch_held_ff;
      press_start_in  = press_start_ff;
      last_release_in = last_release_ff;
      last_poll_in    = last_poll_ff;
      prev_touch_in   = prev_touch_ff;
      last_edge_in    = last_edge_ff;
      if (step) begin
         prev_a_in = item.encoder_a;
         if (press_start) begin
            switch_held_in = 1'b1;
            press_start_in = item.now_ms;
         end else if (release_seen) begin
            switch_held_in = 1'b0;
            if (release_ok) begin
               last_release_in = item.now_ms;
            end
         end
         if (poll_due) begin
            last_poll_in  = item.now_ms;
            prev_touch_in = item.touch_active;
            if (touch_hit) begin
               last_edge_in = item.now_ms;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff       <= 1'b1;
         switch_held_ff  <= 1'b0;
         press_start_ff  <= '0;
         last_release_ff <= '0;
         last_poll_ff    <= '0;
         prev_touch_ff   <= 1'b0;
         last_edge_ff    <= '0;
      end else begin
         prev_a_ff       <= prev_a_in;
         switch_held_ff  <= switch_held_in;
         press_start_ff  <= press_start_in;
         last_release_ff <= last_release_in;
         last_poll_ff    <= last_poll_in;
         prev_touch_ff   <= prev_touch_in;
         last_edge_ff    <= last_edge_in;
      end
   end

endmodule

// ===== rtl/core/encoder_button_touch_qualifier_unit.sv =====
// Rotary encoder, push switch and touch qualifier. Each request is one poll
// of the pins with a millisecond timestamp and returns exactly one response
// with five event flags. A poll is taken into an input register, qualified
// combinationally against the stored pin history and timing registers, and
// the flags land in a result register. One poll per clock is sustained while
// the responder takes each result. Timing registers are to be written over the
// csr channel only while no poll is in flight; the block does not enforce it.
// Depends on ebtq_pkg, ebtq_if, ebtq_csr and ebtq_qual.
module encoder_button_touch_qualifier_unit
   import ebtq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ebtq_req_if.sink  req_chan,
   ebtq_rsp_if.source rsp_chan,
   ebtq_csr_if.sink  csr_chan
);

   ebtq_cfg_type    cfg;
   ebtq_item_type   item_ff;
   ebtq_result_type result;
   ebtq_result_type result_ff;
   logic            in_valid_ff, in_valid_in;
   logic            out_valid_ff, out_valid_in;
   logic            advance;
   logic            take_req;

   ebtq_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ebtq_qual u_qual (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (item_ff),
      .step   (advance),
      .result (result)
   );

   // Move a request to the result register when that register frees up
   assign advance  = in_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign take_req = req_chan.valid & req_chan.ready;
   assign req_chan.ready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in  = take_req | (in_valid_ff & ~advance);
      out_valid_in = advance | (out_valid_ff & ~rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture request payload and hold the response payload
   always_ff @(posedge clock) begin
      if (take_req) begin
         item_ff.encoder_a      <= req_chan.encoder_a;
         item_ff.encoder_b      <= req_chan.encoder_b;
         item_ff.switch_pressed <= req_chan.switch_pressed;
         item_ff.touch_active   <= req_chan.touch_active;
         item_ff.now_ms         <= req_chan.now_ms;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid                  = out_valid_ff;
   assign rsp_chan.step_clockwise         = result_ff.step_clockwise;
   assign rsp_chan.step_counter_clockwise = result_ff.step_counter_clockwise;
   assign rsp_chan.short_press            = result_ff.short_press;
   assign rsp_chan.long_press             = result_ff.long_press;
   assign rsp_chan.touch_press            = result_ff.touch_press;

endmodule
